// ===== src/fp_register_stack_tag_unit_core_macros.svh =====
// Assertion macros shared by the register stack RTL.
`ifndef FP_REGISTER_STACK_TAG_UNIT_CORE_MACROS_SVH
`define FP_REGISTER_STACK_TAG_UNIT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fprstu_pkg.sv =====
// Package: types and constants of the floating-point register stack.
`default_nettype none

package fprstu_pkg;

  // Operation selector codes
  typedef enum logic [2:0] {
    FN_LOAD_MEM  = 3'd0,
    FN_LOAD_REG  = 3'd1,
    FN_STORE_OUT = 3'd2,
    FN_STORE_REG = 3'd3,
    FN_FREE      = 3'd4,
    FN_RD_CTRL   = 3'd5,
    FN_INC_TOP   = 3'd6,
    FN_NOP       = 3'd7
  } func_t;

  // Status word bits
  localparam logic [15:0] SW_IE = 16'h0001;
  localparam logic [15:0] SW_DE = 16'h0002;
  localparam logic [15:0] SW_SF = 16'h0040;
  localparam logic [15:0] SW_ES = 16'h0080;
  localparam logic [15:0] SW_C1 = 16'h0200;
  localparam int unsigned SW_TOP_LSB = 11;
  localparam int unsigned SW_TOP_MSB = 13;

  // Control word: reset value and exception mask field
  localparam logic [15:0] CW_RESET    = 16'h037F;
  localparam logic [15:0] CW_EXC_MASK = 16'h003F;

  // Exponent field of an 80-bit value
  localparam logic [14:0] EXP_ONES = 15'h7FFF;

  localparam int unsigned NUM_REGS = 8;

  // Input transfer payload
  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  stack_index;
    logic [63:0] load_significand;
    logic [15:0] load_sign_exponent;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic [63:0] store_significand;
    logic [15:0] store_sign_exponent;
    logic        store_valid;
    logic [15:0] status_word;
    logic [15:0] control_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/fp_register_stack_tag_unit_core.sv =====
// Top level: x87-style register stack with TOP pointer, tags and status word.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | input     | in_valid / in_stall  | in_data  (fprstu_pkg::in_item_t)
//  out     | output    | out_valid / out_stall| out_data (fprstu_pkg::out_item_t)
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (control word)
//
// An accepted item sits in the input register; its operation is done in one pass
// against the stack registers once the result register can take it, and the result
// is registered. One item per cycle sustained while out_stall stays low, since every
// operation finishes in a single pass of that stage.
// rst_n (synchronous) empties all eight registers, clears TOP and status.
// A stalled result holds the operation stage, which then stalls the input.
`default_nettype none

`include "fp_register_stack_tag_unit_core_macros.svh"

module fp_register_stack_tag_unit_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire fprstu_pkg::in_item_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output fprstu_pkg::out_item_t     out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [15:0]          cfg_wr_data
);

  // Value classification helpers
  function automatic logic is_denormal(input logic [63:0] sig, input logic [15:0] se);
    return (se[14:0] == 15'd0) && (sig != 64'd0);
  endfunction

  function automatic logic is_nan(input logic [63:0] sig, input logic [15:0] se);
    return (se[14:0] == fprstu_pkg::EXP_ONES) && (sig[62:0] != 63'd0);
  endfunction

  // Sticky flag update; ES on an unmasked exception or a stack fault
  function automatic logic [15:0] raise_flags(input logic [15:0] flags,
                                              input logic [15:0] f,
                                              input logic [15:0] cw);
    logic [15:0] res;
    res = flags | f;
    if (((f & ~cw & fprstu_pkg::CW_EXC_MASK) != 16'd0) ||
        ((f & fprstu_pkg::SW_SF) != 16'd0)) begin
      res = res | fprstu_pkg::SW_ES;
    end
    return res;
  endfunction

  // Registers
  logic                           in_vld_r;
  fprstu_pkg::in_item_t           in_r;
  logic                           out_vld_r;
  fprstu_pkg::out_item_t          out_r;
  fprstu_pkg::out_item_t          out_nxt;
  logic [15:0]                    cw_r;
  logic [2:0]                     top_r, top_nxt;
  logic [15:0]                    flags_r, flags_nxt;
  logic [fprstu_pkg::NUM_REGS-1:0] empty_r, empty_nxt;
  logic [63:0]                    sig_mem [fprstu_pkg::NUM_REGS];
  logic [15:0]                    se_mem  [fprstu_pkg::NUM_REGS];

  // Operation stage signals
  logic                           fire;
  fprstu_pkg::func_t              func;
  logic [2:0]                     top_dec;
  logic [2:0]                     rel;
  logic [2:0]                     rd_addr;
  logic [63:0]                    rd_sig;
  logic [15:0]                    rd_se;
  logic                           wr_en;
  logic [2:0]                     wr_addr;
  logic [63:0]                    wr_sig;
  logic [15:0]                    wr_se;
  logic [15:0]                    fl;
  logic                           push_ok;
  logic                           pop_ok;

  // Handshake
  assign fire      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Address generation and the single value read port
  assign func    = fprstu_pkg::func_t'(in_r.func);
  assign top_dec = top_r - 3'd1;
  assign rel     = top_r + in_r.stack_index;
  assign rd_addr = (func == fprstu_pkg::FN_LOAD_REG) ? rel : top_r;
  assign rd_sig  = sig_mem[rd_addr];
  assign rd_se   = se_mem[rd_addr];

  // Operation decode and state update
  always_comb begin
    fl        = 16'd0;
    flags_nxt = flags_r;
    top_nxt   = top_r;
    empty_nxt = empty_r;
    wr_en     = 1'b0;
    wr_addr   = top_dec;
    wr_sig    = in_r.load_significand;
    wr_se     = in_r.load_sign_exponent;
    push_ok   = 1'b0;
    pop_ok    = 1'b0;
    out_nxt   = '0;
    unique case (func)
      fprstu_pkg::FN_LOAD_MEM, fprstu_pkg::FN_LOAD_REG: begin
        if (!empty_r[top_dec]) begin
          flags_nxt = raise_flags(flags_r,
                      fprstu_pkg::SW_IE | fprstu_pkg::SW_SF | fprstu_pkg::SW_C1, cw_r);
        end else if (func == fprstu_pkg::FN_LOAD_REG && empty_r[rel]) begin
          flags_nxt = raise_flags(flags_r, fprstu_pkg::SW_IE | fprstu_pkg::SW_SF, cw_r);
        end else begin
          push_ok = 1'b1;
          if (func == fprstu_pkg::FN_LOAD_REG) begin
            wr_sig = rd_sig;
            wr_se  = rd_se;
          end else if (is_denormal(in_r.load_significand, in_r.load_sign_exponent)) begin
            fl = fprstu_pkg::SW_DE;
          end else if (is_nan(in_r.load_significand, in_r.load_sign_exponent)) begin
            fl = fprstu_pkg::SW_IE;
          end
          wr_en              = 1'b1;
          top_nxt            = top_dec;
          empty_nxt[top_dec] = 1'b0;
          flags_nxt          = raise_flags(flags_r & ~fprstu_pkg::SW_C1, fl, cw_r);
        end
      end
      fprstu_pkg::FN_STORE_OUT, fprstu_pkg::FN_STORE_REG: begin
        if (empty_r[top_r]) begin
          flags_nxt = raise_flags(flags_r,
                      fprstu_pkg::SW_IE | fprstu_pkg::SW_SF | fprstu_pkg::SW_C1, cw_r);
        end else begin
          pop_ok = 1'b1;
          if (is_nan(rd_sig, rd_se)) begin
            fl = fl | fprstu_pkg::SW_IE;
          end
          if (is_denormal(rd_sig, rd_se)) begin
            fl = fl | fprstu_pkg::SW_DE;
          end
          if (func == fprstu_pkg::FN_STORE_OUT) begin
            out_nxt.store_significand   = rd_sig;
            out_nxt.store_sign_exponent = rd_se;
            out_nxt.store_valid         = 1'b1;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = rel;
            wr_sig         = rd_sig;
            wr_se          = rd_se;
            empty_nxt[rel] = 1'b0;
          end
          // popping last, so a store to ST(0) leaves it empty
          empty_nxt[top_r] = 1'b1;
          top_nxt          = top_r + 3'd1;
          flags_nxt        = raise_flags(flags_r & ~fprstu_pkg::SW_C1, fl, cw_r);
        end
      end
      fprstu_pkg::FN_FREE: begin
        empty_nxt[rel] = 1'b1;
      end
      fprstu_pkg::FN_RD_CTRL: begin
        out_nxt.control_out = cw_r;
      end
      fprstu_pkg::FN_INC_TOP: begin
        top_nxt   = top_r + 3'd1;
        flags_nxt = flags_r & ~fprstu_pkg::SW_C1;
      end
      fprstu_pkg::FN_NOP: begin
        flags_nxt = flags_r;
      end
      default: begin
        flags_nxt = flags_r;
      end
    endcase
    flags_nxt[fprstu_pkg::SW_TOP_MSB:fprstu_pkg::SW_TOP_LSB] = top_nxt;
    out_nxt.status_word = flags_nxt;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  // Control word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= fprstu_pkg::CW_RESET;
    end else if (cfg_wr_en) begin
      cw_r <= cfg_wr_data;
    end
  end

  // Stack control state: TOP, empty tags, sticky flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= 3'd0;
      flags_r <= 16'd0;
      empty_r <= '1;
    end else if (fire) begin
      top_r   <= top_nxt;
      flags_r <= flags_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Register file values
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      sig_mem[wr_addr] <= wr_sig;
      se_mem[wr_addr]  <= wr_se;
    end
  end

  // Checks
  `FPRS_ASSERT_NOW(a_sf_implies_es, (flags_r & fprstu_pkg::SW_SF) != 16'd0,
                   (flags_r & fprstu_pkg::SW_ES) != 16'd0, "stack fault without ES")
  `FPRS_ASSERT_NEXT(a_push_fills_st0, fire && push_ok, !empty_r[top_r], "pushed ST0 empty")
  `FPRS_ASSERT_NEXT(a_pop_moves_top, fire && pop_ok, top_r == $past(top_r) + 3'd1, "pop TOP")
  `FPRS_ASSERT_NEXT(a_fire_gives_result, fire, out_vld_r, "result lost")

endmodule

`default_nettype wire
